FILE: rtl/tcpq_pkg.sv
package tcpq_pkg;
  localparam int unsigned QueueDepthDefault = 16;
  localparam int unsigned IdW = 16;
  localparam int unsigned AgeW = 9;
  localparam int unsigned CntOutW = 5;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_SERVE  = 2'd1,
    CMD_CANCEL = 2'd2,
    CMD_QUERY  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_REJECT  = 2'd1,
    ST_MISSING = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  localparam logic [AgeW-1:0] AgeAbsent = '1;
  localparam logic [7:0] ThresholdReset = 8'd65;

  typedef struct packed {
    cmd_e            cmd;
    logic [IdW-1:0]  id;
    logic [AgeW-1:0] age;
    logic            age_neg;
    logic            pref_class;
  } op_t;
endpackage

FILE: rtl/tcpq_if.sv
interface tcpq_cmd_if
  import tcpq_pkg::*;
();
  logic            valid;
  logic            ready;
  logic [1:0]      cmd;
  logic [IdW-1:0]  entry_id;
  logic [AgeW-1:0] entry_age;
  modport source (output valid, cmd, entry_id, entry_age, input ready);
  modport sink (input valid, cmd, entry_id, entry_age, output ready);
endinterface

interface tcpq_res_if
  import tcpq_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [IdW-1:0]     served_id;
  logic [AgeW-1:0]    queried_age;
  logic [CntOutW-1:0] entry_count;
  modport source (output valid, status, served_id, queried_age, entry_count, input ready);
  modport sink (input valid, status, served_id, queried_age, entry_count, output ready);
endinterface

interface tcpq_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

FILE: rtl/tcpq_front.sv
module tcpq_front
  import tcpq_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  tcpq_cmd_if.sink   cmd_if,
  tcpq_cfg_if.sink   cfg_if,
  output logic       op_valid_o,
  output op_t        op_o,
  input  logic       op_ready_i
);
  logic [7:0] thr_q;
  logic       full_q;
  op_t        op_q;

  assign cfg_if.ready = 1'b1;
  assign cmd_if.ready = !full_q || op_ready_i;
  assign op_valid_o   = full_q;
  assign op_o         = op_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= ThresholdReset;
      full_q <= 1'b0;
    end else begin
      if (cfg_if.valid) begin
        thr_q <= cfg_if.data;
      end
      if (cmd_if.valid && cmd_if.ready) begin
        full_q <= 1'b1;
      end else if (op_ready_i) begin
        full_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_if.valid && cmd_if.ready) begin
      op_q.cmd        <= cmd_e'(cmd_if.cmd);
      op_q.id         <= cmd_if.entry_id;
      op_q.age        <= cmd_if.entry_age;
      op_q.age_neg    <= cmd_if.entry_age[AgeW-1];
      op_q.pref_class <= cmd_if.entry_age[AgeW-2:0] >= thr_q;
    end
  end
endmodule

FILE: rtl/tcpq_back.sv
module tcpq_back
  import tcpq_pkg::*;
#(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      op_valid_i,
  input  op_t       op_i,
  output logic      op_ready_o,
  tcpq_res_if.source res_if
);
  localparam int unsigned IdxW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam logic [CntW-1:0] Depth = CntW'(QueueDepth);

  logic [IdW-1:0]  p_id_q [QueueDepth];
  logic [AgeW-1:0] p_age_q[QueueDepth];
  logic [IdW-1:0]  n_id_q [QueueDepth];
  logic [AgeW-1:0] n_age_q[QueueDepth];
  logic [CntW-1:0] p_cnt_q, n_cnt_q, p_cnt_d, n_cnt_d;

  // search result, registered between the search and the update
  logic [QueueDepth-1:0] p_hit, n_hit, p_hit_q, n_hit_q;
  logic                  phase_q;
  logic                  res_valid_q;
  logic [1:0]            st_q;
  logic [IdW-1:0]        sid_q;
  logic [AgeW-1:0]       qage_q;
  logic [CntOutW-1:0]    cnt_o_q;

  always_comb begin
    for (int i = 0; i < QueueDepth; i++) begin
      p_hit[i] = (CntW'(i) < p_cnt_q) && (p_id_q[i] == op_i.id);
      n_hit[i] = (CntW'(i) < n_cnt_q) && (n_id_q[i] == op_i.id);
    end
  end

  logic            fire, p_any, n_any, p_rm, n_rm, p_ins, n_ins;
  logic [1:0]      st_d;
  logic [IdW-1:0]  sid_d;
  logic [AgeW-1:0] qage_d;
  logic [QueueDepth-1:0] p_mask, n_mask;

  assign op_ready_o = phase_q && (!res_valid_q || res_if.ready);
  assign fire  = op_valid_i && op_ready_o;
  assign p_any = |p_hit_q;
  assign n_any = |n_hit_q;

  always_comb begin
    st_d = ST_DONE; sid_d = '0; qage_d = '0;
    p_rm = 1'b0; n_rm = 1'b0; p_ins = 1'b0; n_ins = 1'b0;
    p_mask = '0; n_mask = '0;
    p_cnt_d = p_cnt_q; n_cnt_d = n_cnt_q;
    for (int i = 0; i < QueueDepth; i++) begin
      if (p_hit_q[i]) qage_d = p_age_q[i];
    end
    if (!p_any) begin
      for (int i = 0; i < QueueDepth; i++) begin
        if (n_hit_q[i]) qage_d = n_age_q[i];
      end
    end
    unique case (op_i.cmd)
      CMD_INSERT: begin
        qage_d = '0;
        if (op_i.age_neg || p_any || n_any) st_d = ST_REJECT;
        else if (CntW'(p_cnt_q + n_cnt_q) >= Depth) st_d = ST_FULL;
        else if (op_i.pref_class) p_ins = 1'b1;
        else n_ins = 1'b1;
      end
      CMD_SERVE: begin
        qage_d = '0;
        if (p_cnt_q != '0) begin
          sid_d = p_id_q[0]; p_rm = 1'b1; p_mask[0] = 1'b1;
        end else if (n_cnt_q != '0) begin
          sid_d = n_id_q[0]; n_rm = 1'b1; n_mask[0] = 1'b1;
        end else st_d = ST_MISSING;
      end
      CMD_CANCEL: begin
        qage_d = '0;
        if (p_any) begin p_rm = 1'b1; p_mask = p_hit_q; end
        else if (n_any) begin n_rm = 1'b1; n_mask = n_hit_q; end
        else st_d = ST_MISSING;
      end
      CMD_QUERY: begin
        if (!p_any && !n_any) begin st_d = ST_MISSING; qage_d = AgeAbsent; end
      end
      default: ;
    endcase
    if (p_ins) p_cnt_d = p_cnt_q + 1'b1;
    if (n_ins) n_cnt_d = n_cnt_q + 1'b1;
    if (p_rm)  p_cnt_d = p_cnt_q - 1'b1;
    if (n_rm)  n_cnt_d = n_cnt_q - 1'b1;
  end

  // shift-down masks: slot i shifts when at or above the removed slot
  logic [QueueDepth-1:0] p_sh, n_sh;
  always_comb begin
    p_sh = '0; n_sh = '0;
    p_sh[0] = p_mask[0];
    n_sh[0] = n_mask[0];
    for (int i = 1; i < QueueDepth; i++) begin
      p_sh[i] = p_mask[i] || p_sh[i-1];
      n_sh[i] = n_mask[i] || n_sh[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (!phase_q) begin
      p_hit_q <= p_hit;
      n_hit_q <= n_hit;
    end
    if (fire) begin
      for (int i = 0; i < QueueDepth; i++) begin
        if (p_rm && p_sh[i] && i + 1 < QueueDepth) begin
          p_id_q[i]  <= p_id_q[(i + 1 < QueueDepth) ? i+1 : i];
          p_age_q[i] <= p_age_q[(i + 1 < QueueDepth) ? i+1 : i];
        end
        if (n_rm && n_sh[i] && i + 1 < QueueDepth) begin
          n_id_q[i]  <= n_id_q[(i + 1 < QueueDepth) ? i+1 : i];
          n_age_q[i] <= n_age_q[(i + 1 < QueueDepth) ? i+1 : i];
        end
      end
      if (p_ins) begin
        p_id_q[p_cnt_q[IdxW-1:0]]  <= op_i.id;
        p_age_q[p_cnt_q[IdxW-1:0]] <= op_i.age;
      end
      if (n_ins) begin
        n_id_q[n_cnt_q[IdxW-1:0]]  <= op_i.id;
        n_age_q[n_cnt_q[IdxW-1:0]] <= op_i.age;
      end
      st_q    <= st_d;
      sid_q   <= sid_d;
      qage_q  <= qage_d;
      cnt_o_q <= CntOutW'(p_cnt_d + n_cnt_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_cnt_q <= '0;
      n_cnt_q <= '0;
      phase_q <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        p_cnt_q <= p_cnt_d;
        n_cnt_q <= n_cnt_d;
        phase_q <= 1'b0;
        res_valid_q <= 1'b1;
      end else begin
        if (res_if.ready) res_valid_q <= 1'b0;
        if (op_valid_i) phase_q <= 1'b1;
      end
    end
  end

  assign res_if.valid       = res_valid_q;
  assign res_if.status      = st_q;
  assign res_if.served_id   = sid_q;
  assign res_if.queried_age = qage_q;
  assign res_if.entry_count = cnt_o_q;
endmodule

FILE: rtl/two_class_priority_queue_unit.sv
// channel | dir | payload
// cmd     | in  | cmd, entry_id, entry_age
// res     | out | status, served_id, queried_age, entry_count
// cfg     | in  | pref_threshold
// Back end per beat: id compare over both classes, then
// update with shift removal. One beat buffered in front, one result register.
// Reset clears counts and sets threshold to 65; entry storage is unreset.
// Either side may stall; the front takes no new beat while one waits.
module two_class_priority_queue_unit
  import tcpq_pkg::*;
#(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  tcpq_cmd_if.sink   cmd_if,
  tcpq_cfg_if.sink   cfg_if,
  tcpq_res_if.source res_if
);
  logic op_valid, op_ready;
  op_t  op;

  tcpq_front u_front (
    .clk_i, .rst_ni, .cmd_if, .cfg_if,
    .op_valid_o(op_valid), .op_o(op), .op_ready_i(op_ready)
  );

  tcpq_back #(.QueueDepth(QueueDepth)) u_back (
    .clk_i, .rst_ni, .op_valid_i(op_valid), .op_i(op),
    .op_ready_o(op_ready), .res_if
  );

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_if.valid && !res_if.ready |=> res_if.valid)
    else $error("result dropped");
  a_nofire_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_ready && op_valid |=> !op_ready)
    else $error("back end skipped search cycle");
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_if.valid |-> res_if.entry_count <= CntOutW'(QueueDepth))
    else $error("count overflow");
endmodule
